// File: src/keyed_counter_table_core_macros.svh
// Assertion macros used by the checker module of the keyed counter table.
`ifndef KEYED_COUNTER_TABLE_CORE_MACROS_SVH
`define KEYED_COUNTER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define KCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed counter table check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed counter table check failed");

`endif

// File: src/kct_pkg.sv
package kct_pkg;

  localparam int TABLE_ENTRIES = 64;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 31;
  localparam int CNT_W  = 31;
  localparam int ST_W   = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

  localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // One request as it travels along the chain of cells.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  new_count;
    logic [CNT_W-1:0]  count;
    logic [ST_W-1:0]   status;
  } req_t;

endpackage

// File: src/kct_cell.sv
module kct_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  kct_pkg::req_t req_i,
  output kct_pkg::req_t req_o
);
  import kct_pkg::*;

  logic             ent_valid_r;
  logic [KEY_W-1:0] ent_key_r;
  logic [CNT_W-1:0] ent_count_r;
  req_t             req_r;
  req_t             req_nxt;
  logic             hit;
  logic             ins;
  logic             cnt_wr;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  assign hit     = ent_valid_r && (ent_key_r == req_i.key);
  assign cnt_inc = (ent_count_r == COUNT_MAX) ? ent_count_r : ent_count_r + COUNT_ONE;

  always_comb begin
    req_nxt = req_i;
    ins     = 1'b0;
    cnt_wr  = 1'b0;
    cnt_nxt = ent_count_r;
    if (req_i.valid && !req_i.done) begin
      if (hit) begin
        req_nxt.done   = 1'b1;
        req_nxt.status = ST_OK;
        case (req_i.func)
          FUNC_ADD: begin
            cnt_wr        = 1'b1;
            cnt_nxt       = cnt_inc;
            req_nxt.count = cnt_inc;
          end
          FUNC_SET: begin
            cnt_wr        = 1'b1;
            cnt_nxt       = req_i.new_count;
            req_nxt.count = req_i.new_count;
          end
          default: begin
            req_nxt.count = ent_count_r;
          end
        endcase
      end else if (!ent_valid_r) begin
        // Entries fill from the bottom up, so no later cell can hold this key.
        req_nxt.done = 1'b1;
        case (req_i.func)
          FUNC_ADD: begin
            ins            = 1'b1;
            cnt_wr         = 1'b1;
            cnt_nxt        = COUNT_ONE;
            req_nxt.count  = COUNT_ONE;
            req_nxt.status = ST_OK;
          end
          FUNC_SET: begin
            ins            = 1'b1;
            cnt_wr         = 1'b1;
            cnt_nxt        = req_i.new_count;
            req_nxt.count  = req_i.new_count;
            req_nxt.status = ST_OK;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (adv && ins) begin
      ent_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ins) begin
      ent_key_r <= req_i.key;
    end
    if (adv && cnt_wr) begin
      ent_count_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else if (adv) begin
      req_r <= req_nxt;
    end
  end

  assign req_o = req_r;

endmodule

// File: src/keyed_counter_table_core.sv
// Keyed counter table: pairs keys with saturating counts in a fixed set of entries.
// Input channel: in_valid, in_func, in_key, in_new_count; the block drives in_stall.
// A request is add one, get count or set count; each request gives one result on
// out_count_out and out_status, with out_valid and the receiver's out_stall.
// The table is a chain of TABLE_ENTRIES cells, each holding one entry and one
// pipeline register. A request walks the chain one cell per cycle while the chain
// is not held, and its result shows on out_valid once it has passed the register
// of the last cell. One request is accepted every cycle while the output is not
// stalled.
// A new key takes the lowest free entry; with none free, add and set report
// table full and change nothing. A get of an absent key reports not found.
// While out_valid is high and out_stall is high the whole chain holds and
// in_stall is raised in the same cycle.
// Reset is sampled at the clock edge; it clears all entry valid bits and empties the chain.
module keyed_counter_table_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kct_pkg::FUNC_W-1:0] in_func,
  input  logic [kct_pkg::KEY_W-1:0]  in_key,
  input  logic [kct_pkg::CNT_W-1:0]  in_new_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kct_pkg::CNT_W-1:0]  out_count_out,
  output logic [kct_pkg::ST_W-1:0]   out_status
);
  import kct_pkg::*;

  req_t chain [0:TABLE_ENTRIES];
  req_t req_in;
  logic adv;

  assign adv      = !chain[TABLE_ENTRIES].valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    req_in.valid     = in_valid;
    req_in.func      = in_func;
    req_in.key       = in_key;
    req_in.new_count = in_new_count;
    req_in.count     = '0;
    req_in.done      = 1'b0;
    case (in_func)
      FUNC_ADD: req_in.status = ST_FULL;
      FUNC_SET: req_in.status = ST_FULL;
      FUNC_GET: req_in.status = ST_NOT_FOUND;
      default: begin
        req_in.status = ST_OK;
        req_in.done   = 1'b1;
      end
    endcase
  end

  assign chain[0] = req_in;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    kct_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .req_i (chain[i]),
      .req_o (chain[i+1])
    );
  end

  assign out_valid     = chain[TABLE_ENTRIES].valid;
  assign out_count_out = chain[TABLE_ENTRIES].count;
  assign out_status    = chain[TABLE_ENTRIES].status;

endmodule

// File: src/kct_checker.sv
`include "keyed_counter_table_core_macros.svh"

module kct_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [kct_pkg::CNT_W-1:0]  out_count_out,
  input logic [kct_pkg::ST_W-1:0]   out_status
);
  import kct_pkg::*;

  `KCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `KCT_ASSERT_NOW(a_stall_link, 1'b1, in_stall == (out_valid && out_stall))
  `KCT_ASSERT_NOW(a_miss_zero, out_valid && (out_status == ST_NOT_FOUND), out_count_out == '0)
  `KCT_ASSERT_NOW(a_full_zero, out_valid && (out_status == ST_FULL), out_count_out == '0)

endmodule

bind keyed_counter_table_core kct_checker u_kct_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_count_out (out_count_out),
  .out_status    (out_status)
);
